/* hw/rtl/flash_chunk_deframer_defines.svh */
// Assertion macros for the deframer
`ifndef FLASH_CHUNK_DEFRAMER_DEFINES_SVH
`define FLASH_CHUNK_DEFRAMER_DEFINES_SVH

// check on every rising clock edge, reset included
`define FCD_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// check outside of reset
`define FCD_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* hw/rtl/fcd_pkg.sv */
package fcd_pkg;

   localparam int OFF_W_MAX = 24;
   localparam int ADDR_W    = 25;
   localparam int DATA_W    = 8;
   localparam int CNT_W     = 16;
   localparam int STAT_W    = 2;
   localparam int KIND_W    = 2;
   localparam int TDATA_W   = 104;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BAD_MK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_MARK   = 2'd1;
   localparam logic [STAT_W-1:0] ST_TRUNC     = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_MK    = 2'd3;

   localparam logic [7:0] FMT_EXT  = 8'h80;
   localparam logic [7:0] MARK_LO  = 8'h34;
   localparam logic [7:0] MARK_HI  = 8'h82;
   localparam logic [7:0] TAIL_LEN = 8'd3;

   localparam int QDEPTH = 4;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ADDR_W-1:0]    write_address;
      logic [DATA_W-1:0]    write_data;
      logic [CNT_W-1:0]     chunks_seen;
      logic [OFF_W_MAX-1:0] image_start;
      logic [ADDR_W-1:0]    image_size;
      logic [STAT_W-1:0]    status;
      logic                 end_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

/* hw/rtl/fcd_parser.sv */
`include "flash_chunk_deframer_defines.svh"

module fcd_parser #(
   parameter int ADDR_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_eof,
   input  logic                 trim,
   output fcd_pkg::push_type    push
);

   localparam int OFF_W = (ADDR_BITS < fcd_pkg::OFF_W_MAX) ? ADDR_BITS : fcd_pkg::OFF_W_MAX;
   localparam logic [fcd_pkg::OFF_W_MAX-1:0] OFF_MASK =
      fcd_pkg::OFF_W_MAX'((64'd1 << OFF_W) - 64'd1);

   localparam logic [3:0] PH_SEARCH = 4'd0;
   localparam logic [3:0] PH_FMT    = 4'd1;
   localparam logic [3:0] PH_SRC    = 4'd2;
   localparam logic [3:0] PH_TGT    = 4'd3;
   localparam logic [3:0] PH_LEN    = 4'd4;
   localparam logic [3:0] PH_MK1    = 4'd5;
   localparam logic [3:0] PH_MK2    = 4'd6;
   localparam logic [3:0] PH_OFH    = 4'd7;
   localparam logic [3:0] PH_OFM    = 4'd8;
   localparam logic [3:0] PH_OFL    = 4'd9;
   localparam logic [3:0] PH_CLEN   = 4'd10;
   localparam logic [3:0] PH_DATA   = 4'd11;
   localparam logic [3:0] PH_TAIL   = 4'd12;
   localparam logic [3:0] PH_STOP   = 4'd13;

   logic [3:0]                        phase_ff,       phase_in;
   logic [7:0]                        prev_ff,        prev_in;
   logic [fcd_pkg::OFF_W_MAX-1:0]     offset_ff,      offset_in;
   logic [7:0]                        length_ff,      length_in;
   logic [7:0]                        index_ff,       index_in;
   logic [fcd_pkg::OFF_W_MAX-1:0]     first_ff,       first_in;
   logic [fcd_pkg::CNT_W-1:0]         total_ff,       total_in;
   logic [fcd_pkg::STAT_W-1:0]        stop_ff,        stop_in;
   logic                              ext_ff,         ext_in;
   logic [fcd_pkg::ADDR_W-1:0]        last_end_ff,    last_end_in;

   logic                              r0_valid;
   fcd_pkg::rsp_type                  r0;
   fcd_pkg::rsp_type                  sum;
   logic [7:0]                        index_inc;
   logic [fcd_pkg::OFF_W_MAX-1:0]     start;
   logic [fcd_pkg::ADDR_W-1:0]        start_ext;
   logic                              marker_ok;

   assign index_inc = index_ff + 8'd1;
   assign marker_ok = (prev_ff == fcd_pkg::MARK_LO) && (in_byte == fcd_pkg::MARK_HI);

   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      length_in   = length_ff;
      index_in    = index_ff;
      first_in    = first_ff;
      total_in    = total_ff;
      stop_in     = stop_ff;
      ext_in      = ext_ff;
      last_end_in = last_end_ff;
      r0_valid    = 1'b0;
      r0          = '0;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (marker_ok) phase_in = PH_OFH;
         end
         PH_FMT: begin
            ext_in   = (in_byte == fcd_pkg::FMT_EXT);
            phase_in = PH_SRC;
         end
         PH_SRC: phase_in = PH_TGT;
         PH_TGT: phase_in = ext_ff ? PH_LEN : PH_MK1;
         PH_LEN: phase_in = PH_MK1;
         PH_MK1: phase_in = PH_MK2;
         PH_MK2: begin
            if (marker_ok) begin
               phase_in = PH_OFH;
            end else begin
               r0_valid = 1'b1;
               r0.kind  = fcd_pkg::KIND_BAD_MK;
               stop_in  = fcd_pkg::ST_BAD_MK;
               phase_in = PH_STOP;
            end
         end
         PH_OFH: begin
            offset_in = {in_byte, 16'h0000};
            phase_in  = PH_OFM;
         end
         PH_OFM: begin
            offset_in = {offset_ff[23:16], in_byte, offset_ff[7:0]};
            phase_in  = PH_OFL;
         end
         PH_OFL: begin
            offset_in = {offset_ff[23:8], in_byte} & OFF_MASK;
            phase_in  = PH_CLEN;
         end
         PH_CLEN: begin
            length_in = in_byte;
            if (total_ff == '0) first_in = offset_ff;
            if (total_ff != '1) total_in = total_ff + 16'd1;
            last_end_in = fcd_pkg::ADDR_W'(offset_ff) + fcd_pkg::ADDR_W'(in_byte);
            index_in    = 8'd0;
            phase_in    = (in_byte != 8'd0) ? PH_DATA : PH_TAIL;
         end
         PH_DATA: begin
            r0_valid         = 1'b1;
            r0.kind          = fcd_pkg::KIND_WRITE;
            r0.write_address = fcd_pkg::ADDR_W'(offset_ff) + fcd_pkg::ADDR_W'(index_ff);
            r0.write_data    = in_byte;
            index_in         = index_inc;
            if (index_inc == length_ff) begin
               index_in = 8'd0;
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            index_in = index_inc;
            if (index_inc >= fcd_pkg::TAIL_LEN) begin
               index_in = 8'd0;
               phase_in = PH_FMT;
            end
         end
         PH_STOP: phase_in = PH_STOP;
         default: phase_in = PH_SEARCH;
      endcase
   end

   assign start     = trim ? first_in : '0;
   assign start_ext = fcd_pkg::ADDR_W'(start);

   always_comb begin
      sum             = '0;
      sum.kind        = fcd_pkg::KIND_SUMMARY;
      sum.chunks_seen = total_in;
      sum.image_start = start;
      sum.end_of_run  = 1'b1;
      if (total_in != '0 && last_end_in > start_ext) sum.image_size = last_end_in - start_ext;
      priority if (phase_in == PH_SEARCH) sum.status = fcd_pkg::ST_NO_MARK;
      else if (phase_in == PH_STOP)       sum.status = stop_in;
      else if (phase_in == PH_FMT)        sum.status = fcd_pkg::ST_OK;
      else                                sum.status = fcd_pkg::ST_TRUNC;
   end

   always_comb begin
      push = '0;
      if (in_valid) begin
         if (r0_valid) begin
            push.first            = r0;
            push.first.end_of_run = !in_eof;
            push.second           = sum;
            push.num              = in_eof ? 2'd2 : 2'd1;
         end else if (in_eof) begin
            push.first = sum;
            push.num   = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_valid && in_eof)) begin
         phase_ff    <= PH_SEARCH;
         prev_ff     <= '0;
         offset_ff   <= '0;
         length_ff   <= '0;
         index_ff    <= '0;
         first_ff    <= '0;
         total_ff    <= '0;
         stop_ff     <= fcd_pkg::ST_OK;
         ext_ff      <= 1'b0;
         last_end_ff <= '0;
      end else if (in_valid) begin
         phase_ff    <= phase_in;
         prev_ff     <= prev_in;
         offset_ff   <= offset_in;
         length_ff   <= length_in;
         index_ff    <= index_in;
         first_ff    <= first_in;
         total_ff    <= total_in;
         stop_ff     <= stop_in;
         ext_ff      <= ext_in;
         last_end_ff <= last_end_in;
      end
   end

   assign prev_in = in_byte;

   `FCD_ASSERT_RST(a_eof_clears, clock, reset,
      in_valid && in_eof |=> phase_ff == PH_SEARCH && total_ff == '0,
      "run state not cleared after end of file")
   `FCD_ASSERT_RST(a_data_index, clock, reset,
      phase_ff == PH_DATA |-> index_ff < length_ff,
      "payload index past chunk length")
   `FCD_ASSERT_RST(a_stop_holds, clock, reset,
      phase_ff == PH_STOP && !(in_valid && in_eof) |=> phase_ff == PH_STOP,
      "parsing resumed after bad marker")

endmodule

/* hw/rtl/fcd_rsp_queue.sv */
`include "flash_chunk_deframer_defines.svh"

module fcd_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  fcd_pkg::push_type   push,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fcd_pkg::rsp_type    head
);

   fcd_pkg::rsp_type               slot_ff    [fcd_pkg::QDEPTH];
   fcd_pkg::rsp_type               slot_in    [fcd_pkg::QDEPTH];
   fcd_pkg::rsp_type               shifted    [fcd_pkg::QDEPTH];
   logic [fcd_pkg::QCNT_W-1:0]     count_ff,  count_in;
   logic [fcd_pkg::QCNT_W-1:0]     base;
   logic                           pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign ready     = (count_ff <= fcd_pkg::QCNT_W'(fcd_pkg::QDEPTH - 2));
   assign head      = slot_ff[0];
   assign base      = count_ff - fcd_pkg::QCNT_W'(pop);
   assign count_in  = base + fcd_pkg::QCNT_W'(push.num);

   always_comb begin
      for (int i = 0; i < fcd_pkg::QDEPTH - 1; i++) begin
         shifted[i] = slot_ff[i + 1];
      end
      shifted[fcd_pkg::QDEPTH-1] = slot_ff[fcd_pkg::QDEPTH-1];
   end

   always_comb begin
      for (int i = 0; i < fcd_pkg::QDEPTH; i++) begin
         if (push.num != 2'd0 && base == fcd_pkg::QCNT_W'(i)) begin
            slot_in[i] = push.first;
         end else if (push.num == 2'd2 &&
                      base + fcd_pkg::QCNT_W'(1) == fcd_pkg::QCNT_W'(i)) begin
            slot_in[i] = push.second;
         end else if (pop) begin
            slot_in[i] = shifted[i];
         end else begin
            slot_in[i] = slot_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fcd_pkg::QDEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `FCD_ASSERT_RST(a_count_bound, clock, reset,
      count_ff <= fcd_pkg::QCNT_W'(fcd_pkg::QDEPTH),
      "result queue overflow")
   `FCD_ASSERT_RST(a_push_room, clock, reset,
      push.num != 2'd0 |-> ready,
      "word pushed without room")
   `FCD_ASSERT_RST(a_summary_last, clock, reset,
      rsp_valid && head.kind == fcd_pkg::KIND_SUMMARY |-> head.end_of_run,
      "summary word not marked last")

endmodule

/* hw/rtl/flash_chunk_deframer.sv */
// Result words are formed combinationally from a taken input word, then queued.
// Throughput: one input word per cycle; a word may produce two results, which
//   drain one per cycle, while rsp_tready is high, from a four-entry result
//   queue; input stalls while the queue holds more than two words.
// Reset: synchronous, active high; clears parse state and queue, sets trim to 1.
module flash_chunk_deframer #(
   parameter int ADDR_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // file_byte
   input  logic          req_tlast,    // end_of_file
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // write_address[24:0], write_data[32:25], chunks_seen[48:33], image_start[72:49],
   // image_size[97:73], status[99:98], zero[103:100]
   output logic [103:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,    // kind
   output logic          rsp_tlast,    // end_of_run
   input  logic          csr_wr_en,
   input  logic          csr_wr_data   // trim_leading_gap
);

   logic               trim_ff;
   logic               accept;
   fcd_pkg::push_type  push;
   fcd_pkg::rsp_type   head;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= 1'b1;
      end else if (csr_wr_en) begin
         trim_ff <= csr_wr_data;
      end
   end

   fcd_parser #(
      .ADDR_BITS (ADDR_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_tdata),
      .in_eof   (req_tlast),
      .trim     (trim_ff),
      .push     (push)
   );

   fcd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .ready     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .head      (head)
   );

   assign rsp_tdata = {4'b0000, head.status, head.image_size, head.image_start,
                       head.chunks_seen, head.write_data, head.write_address};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.end_of_run;

endmodule
